>>> design/rational_number_alu_macros.svh
// Assertion macros for the rational number ALU modules.
// Depends on nothing; included by files that carry assertions.
`ifndef RATIONAL_NUMBER_ALU_MACROS_SVH
`define RATIONAL_NUMBER_ALU_MACROS_SVH

// Implication check on the rising clock edge, off during reset.
`define RNA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication check on the rising clock edge, off during reset.
`define RNA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/rna_pkg.sv
// Package for the rational number ALU: widths, operation codes, command types.
// Depends on nothing.
package rna_pkg;
    localparam int W = 32;
    localparam int CW = 6; // bit counter for the divider

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_EQ  = 3'd1,
        OP_INC = 3'd2,
        OP_DEC = 3'd3,
        OP_RED = 3'd4
    } t_op;

    // Datapath commands from the controller.
    typedef enum logic [3:0] {
        CMD_NONE    = 4'd0,
        CMD_LOAD    = 4'd1,  // capture operands
        CMD_MUL1    = 4'd2,  // an*bd
        CMD_MUL2    = 4'd3,  // ad*bn, ad*bd, finish add
        CMD_SIMPLE  = 4'd4,  // inc, dec, pass through
        CMD_GSEL    = 4'd5,  // load gcd pair from the selected operand
        CMD_DSTART  = 4'd6,  // start a division x / y
        CMD_DSTEP   = 4'd7,  // one restoring division step
        CMD_GNEXT   = 4'd8,  // (x, y) <= (y, rem)
        CMD_QSTART  = 4'd9,  // start num / g
        CMD_QNUM    = 4'd10, // store quotient into num
        CMD_QDSTART = 4'd11, // start den / g
        CMD_QDEN    = 4'd12, // store quotient into den
        CMD_ZERO    = 4'd13, // note a zero gcd
        CMD_FINAL   = 4'd14  // form output
    } t_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic sel_b; // work on operand b
    } t_ctl;

    typedef struct packed {
        logic y_zero;   // gcd y register is zero
        logic x_zero;   // gcd x register is zero
        logic div_last; // divider on its final step
    } t_sts;
endpackage

>>> design/rna_if.sv
// Valid/ready channel interfaces for the rational number ALU.
// Depends on rna_pkg.
interface rna_in_if import rna_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [2:0]          operation;
    logic signed [W-1:0] a_num;
    logic signed [W-1:0] a_den;
    logic signed [W-1:0] b_num;
    logic signed [W-1:0] b_den;
    modport source (output valid, operation, a_num, a_den, b_num, b_den, input ready);
    modport sink (input valid, operation, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rna_out_if import rna_pkg::*; ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] res_num;
    logic signed [W-1:0] res_den;
    logic                is_equal;
    logic                zero_gcd;
    modport source (output valid, res_num, res_den, is_equal, zero_gcd, input ready);
    modport sink (input valid, res_num, res_den, is_equal, zero_gcd, output ready);
endinterface

>>> design/rna_datapath.sv
// Datapath: operand registers, multiplier, shared bit-serial divider, gcd pair.
// Depends on rna_pkg.
module rna_datapath import rna_pkg::*; (
    input  logic                i_clk,
    input  t_ctl                i_ctl,
    input  logic [2:0]          i_operation,
    input  logic signed [W-1:0] i_a_num,
    input  logic signed [W-1:0] i_a_den,
    input  logic signed [W-1:0] i_b_num,
    input  logic signed [W-1:0] i_b_den,
    output t_sts                o_sts,
    output logic signed [W-1:0] o_res_num,
    output logic signed [W-1:0] o_res_den,
    output logic                o_is_equal,
    output logic                o_zero_gcd
);
    logic [2:0]   r_op;
    logic [W-1:0] r_an, r_ad, r_bn, r_bd;
    logic [W-1:0] r_x, r_y;
    logic [W-1:0] r_p;
    logic         r_zero;
    // Divider: unsigned restoring, sign handled around it.
    logic [W-1:0] r_dq, r_drem, r_ddiv;
    logic [CW-1:0] r_dcnt;
    logic         r_qneg, r_rneg;

    logic [W-1:0] w_num, w_den, w_dvd, w_dvs, w_prod;
    logic [W:0]   w_trial;
    logic [W-1:0] w_sum;
    logic [W-1:0] w_q, w_r;

    assign w_num = i_ctl.sel_b ? r_bn : r_an;
    assign w_den = i_ctl.sel_b ? r_bd : r_ad;

    // Multiplier operands by step; the low word is all that is kept.
    always_comb begin
        w_prod = '0;
        case (i_ctl.cmd)
            CMD_MUL1: w_prod = W'(r_an * r_bd);
            CMD_MUL2: w_prod = W'(r_ad * r_bn);
            default:  w_prod = W'(r_ad * r_bd);
        endcase
    end

    // Dividend and divisor for a division start.
    always_comb begin
        case (i_ctl.cmd)
            CMD_QSTART:  w_dvd = w_num;
            CMD_QDSTART: w_dvd = w_den;
            default:     w_dvd = r_x;
        endcase
        w_dvs = r_x;
        if (i_ctl.cmd == CMD_DSTART) w_dvs = r_y;
    end

    assign w_sum   = {r_drem[W-2:0], r_dq[W-1]};
    assign w_trial = {1'b0, w_sum} - {1'b0, r_ddiv};
    assign w_q     = r_qneg ? W'(-r_dq) : r_dq;
    assign w_r     = r_rneg ? W'(-r_drem) : r_drem;

    // Operand, gcd and divider registers.
    always_ff @(posedge i_clk) begin
        unique case (i_ctl.cmd)
            CMD_LOAD: begin
                r_op <= i_operation;
                r_an <= i_a_num;
                r_ad <= i_a_den;
                r_bn <= i_b_num;
                r_bd <= i_b_den;
                r_zero <= 1'b0;
            end
            CMD_MUL1: r_p <= w_prod;
            CMD_MUL2: begin
                r_an <= r_p + w_prod;
                r_ad <= W'(r_ad * r_bd);
            end
            CMD_SIMPLE: begin
                if (r_op == OP_INC) r_an <= r_an + r_ad;
                else if (r_op == OP_DEC) r_an <= r_an - r_ad;
            end
            CMD_GSEL: begin
                r_x <= w_num;
                r_y <= w_den;
            end
            CMD_DSTART, CMD_QSTART, CMD_QDSTART: begin
                r_dq   <= w_dvd[W-1] ? W'(-w_dvd) : w_dvd;
                r_ddiv <= w_dvs[W-1] ? W'(-w_dvs) : w_dvs;
                r_drem <= '0;
                r_dcnt <= '0;
                r_qneg <= w_dvd[W-1] ^ w_dvs[W-1];
                r_rneg <= w_dvd[W-1];
            end
            CMD_DSTEP: begin
                // Shift in one dividend bit, quotient bit goes into the low end.
                if (!w_trial[W]) begin
                    r_drem <= w_trial[W-1:0];
                    r_dq   <= {r_dq[W-2:0], 1'b1};
                end else begin
                    r_drem <= w_sum;
                    r_dq   <= {r_dq[W-2:0], 1'b0};
                end
                r_dcnt <= r_dcnt + 1'b1;
            end
            CMD_GNEXT: begin
                r_x <= r_y;
                r_y <= w_r;
            end
            CMD_QNUM: begin
                if (i_ctl.sel_b) r_bn <= w_q; else r_an <= w_q;
            end
            CMD_QDEN: begin
                if (i_ctl.sel_b) r_bd <= w_q; else r_ad <= w_q;
            end
            CMD_ZERO: r_zero <= 1'b1;
            default: ;
        endcase
    end

    // A divisor of minus one gives the wrapped negation and a zero remainder,
    // which the magnitude divider already yields.
    assign o_sts.y_zero   = (r_y == '0);
    assign o_sts.x_zero   = (r_x == '0);
    assign o_sts.div_last = (r_dcnt == CW'(W - 1));

    assign o_res_num  = r_an;
    assign o_res_den  = r_ad;
    assign o_is_equal = (r_op == OP_EQ) && (r_an == r_bn) && (r_ad == r_bd);
    assign o_zero_gcd = r_zero && ((r_op == OP_EQ) || (r_op == OP_RED));
endmodule

>>> design/rna_ctrl.sv
// Controller: sequences add, inc, dec, pass, reduction and equality over the datapath.
// Depends on rna_pkg and rational_number_alu_macros.svh.
`include "rational_number_alu_macros.svh"
module rna_ctrl import rna_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_operation,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_sts       i_sts,
    output t_ctl       o_ctl
);
    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_MUL1  = 10'b0000000010,
        S_MUL2  = 10'b0000000100,
        S_GSEL  = 10'b0000001000,
        S_GTEST = 10'b0000010000,
        S_DIV   = 10'b0000100000,
        S_QNUM  = 10'b0001000000,
        S_QDEN  = 10'b0010000000,
        S_DONE  = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    // Phase within a reduction division.
    typedef enum logic [1:0] {
        PH_GCD = 2'd0,
        PH_NUM = 2'd1,
        PH_DEN = 2'd2
    } t_phase;

    t_state r_state, n_state;
    t_phase r_ph, n_ph;
    logic   r_selb, n_selb;
    logic   r_ovalid, n_ovalid;
    logic [2:0] r_op, n_op;

    assign o_in_ready  = (r_state == S_IDLE) && !r_ovalid;
    assign o_out_valid = r_ovalid;

    // Next state and commands.
    always_comb begin
        n_state  = r_state;
        n_ph     = r_ph;
        n_selb   = r_selb;
        n_ovalid = r_ovalid && !i_out_ready;
        n_op     = r_op;
        o_ctl.cmd   = CMD_NONE;
        o_ctl.sel_b = r_selb;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_ctl.cmd = CMD_LOAD;
                    n_op   = i_operation;
                    n_selb = 1'b0;
                    if (i_operation == OP_ADD) n_state = S_MUL1;
                    else if (i_operation == OP_EQ || i_operation == OP_RED)
                        n_state = S_GSEL;
                    else n_state = S_DONE;
                end
            end
            S_MUL1: begin
                o_ctl.cmd = CMD_MUL1;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                o_ctl.cmd = CMD_MUL2;
                n_state = S_OUT;
            end
            S_GSEL: begin
                o_ctl.cmd = CMD_GSEL;
                n_state = S_GTEST;
            end
            S_GTEST: begin
                // Euclid loop: divide while y is nonzero, else scale by x.
                if (!i_sts.y_zero) begin
                    o_ctl.cmd = CMD_DSTART;
                    n_ph = PH_GCD;
                    n_state = S_DIV;
                end else if (i_sts.x_zero) begin
                    // A zero gcd leaves the value as it is.
                    o_ctl.cmd = CMD_ZERO;
                    n_state = S_DONE;
                end else begin
                    o_ctl.cmd = CMD_QSTART;
                    n_ph = PH_NUM;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_ctl.cmd = CMD_DSTEP;
                if (i_sts.div_last) begin
                    unique case (r_ph)
                        PH_GCD:  n_state = S_QNUM;
                        PH_NUM:  n_state = S_QNUM;
                        default: n_state = S_QDEN;
                    endcase
                end
            end
            S_QNUM: begin
                if (r_ph == PH_GCD) begin
                    o_ctl.cmd = CMD_GNEXT;
                    n_state = S_GTEST;
                end else begin
                    o_ctl.cmd = CMD_QNUM;
                    n_state = S_QDEN;
                end
            end
            S_QDEN: begin
                // After the numerator quotient, start den / g; after that division, store it.
                if (r_ph == PH_DEN) begin
                    o_ctl.cmd = CMD_QDEN;
                    n_state = S_DONE;
                end else begin
                    o_ctl.cmd = CMD_QDSTART;
                    n_ph = PH_DEN;
                    n_state = S_DIV;
                end
            end
            S_DONE: begin
                if (r_op == OP_EQ && !r_selb) begin
                    n_selb = 1'b1;
                    n_state = S_GSEL;
                end else begin
                    o_ctl.cmd = CMD_SIMPLE;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                n_ovalid = 1'b1;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ph     <= PH_GCD;
            r_selb   <= 1'b0;
            r_ovalid <= 1'b0;
            r_op     <= '0;
        end else begin
            r_state  <= n_state;
            r_ph     <= n_ph;
            r_selb   <= n_selb;
            r_ovalid <= n_ovalid;
            r_op     <= n_op;
        end
    end

    `RNA_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_in_ready, r_state == S_IDLE, "ready outside idle")
    `RNA_ASSERT_NEXT(a_out_after, i_clk, i_rst_n, r_state == S_OUT, r_ovalid, "result not raised")
    `RNA_ASSERT_IMP(a_selb_eq, i_clk, i_rst_n, r_selb && r_state != S_IDLE, r_op == OP_EQ, "b used outside equality")
endmodule

>>> design/rational_number_alu.sv
// Top level of the rational number ALU: controller and datapath.
// Depends on rna_pkg, rna_if, rna_ctrl and rna_datapath.
//
// Channel  Direction  Contents
// s_in     sink       operation, a_num, a_den, b_num, b_den
// m_out    source     res_num, res_den, is_equal, zero_gcd
//
// One item at a time. Reduce runs one division per Euclid step (one 32-step
// serial divider shared by every remainder and quotient) plus two quotients;
// equality reduces both operands in turn.
// Reset is synchronous, active low, and clears the controller only.
// A new item is taken only once the previous result has been taken.
module rational_number_alu import rna_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    rna_in_if.sink    s_in,
    rna_out_if.source m_out
);
    t_ctl w_ctl;
    t_sts w_sts;

    rna_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_in.valid),
        .o_in_ready  (s_in.ready),
        .i_operation (s_in.operation),
        .o_out_valid (m_out.valid),
        .i_out_ready (m_out.ready),
        .i_sts       (w_sts),
        .o_ctl       (w_ctl)
    );

    rna_datapath u_dp (
        .i_clk       (i_clk),
        .i_ctl       (w_ctl),
        .i_operation (s_in.operation),
        .i_a_num     (s_in.a_num),
        .i_a_den     (s_in.a_den),
        .i_b_num     (s_in.b_num),
        .i_b_den     (s_in.b_den),
        .o_sts       (w_sts),
        .o_res_num   (m_out.res_num),
        .o_res_den   (m_out.res_den),
        .o_is_equal  (m_out.is_equal),
        .o_zero_gcd  (m_out.zero_gcd)
    );
endmodule
